// ===== sv/mexp_pkg.sv =====
// Package for the modular exponentiation block.
// Holds field widths, the modulus constants, the controller states and the
// command and status structs. Depends on nothing.
package mexp_pkg;

	localparam int IN_W  = 63;
	localparam int OUT_W = 30;

	// The fixed prime modulus and derived constants.
	localparam logic [OUT_W-1:0] PRIME    = 30'd1000000007;
	localparam logic [31:0]      PRIME_X2 = 32'd2000000014;
	// 2^30 mod p, used to fold the upper part of a wide base.
	localparam logic [OUT_W-1:0] FOLD_C   = 30'((64'd1 << 30) % 64'd1000000007);
	// Barrett factor floor(2^60 / p); it has 31 bits.
	localparam logic [30:0]      MU       = 31'((64'd1 << 60) / 64'd1000000007);

	// Pipeline depth of the modular multiplier.
	localparam int MM_LAT = 4;
	localparam int CNT_W  = $clog2(MM_LAT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_STEP,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;       // take a new item and start the base reduction
		logic issue;      // start square and multiply for the current bit
		logic take_base;  // capture the reduced base
		logic take_step;  // capture square and product, shift the exponent
		logic emit;       // move the result into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic exp_zero;
	} dp_sts_t;

endpackage

// ===== sv/mexp_modmul.sv =====
// Pipelined modular multiplier: (a * b + c) mod p with Barrett reduction.
// Four register stages; depends on mexp_pkg.
module mexp_modmul (
	input  logic                          clk,
	input  logic [32:0]                   op_a,
	input  logic [mexp_pkg::OUT_W-1:0]    op_b,
	input  logic [mexp_pkg::OUT_W-1:0]    op_c,
	output logic [mexp_pkg::OUT_W-1:0]    result
);

	logic [62:0] prod_s1;
	logic [61:0] tq_s2;
	logic [31:0] plo_s2;
	logic [31:0] plo_s3;
	logic [31:0] qp_s3;
	logic [31:0] rem_s4;
	logic [60:0] qp_full;
	logic [32:0] diff1;
	logic [32:0] diff2;

	// The quotient estimate times the prime; only the low 32 bits matter
	// because the true remainder stays below three times the prime.
	assign qp_full = {30'd0, tq_s2[61:31]} * {31'd0, mexp_pkg::PRIME};

	always_ff @(posedge clk) begin
		prod_s1 <= ({30'd0, op_a} * {33'd0, op_b}) + {33'd0, op_c};
		tq_s2   <= {31'd0, prod_s1[59:29]} * {31'd0, mexp_pkg::MU};
		plo_s2  <= prod_s1[31:0];
		plo_s3  <= plo_s2;
		qp_s3   <= qp_full[31:0];
		rem_s4  <= plo_s3 - qp_s3;
	end

	assign diff1 = {1'b0, rem_s4} - {3'd0, mexp_pkg::PRIME};
	assign diff2 = {1'b0, rem_s4} - {1'b0, mexp_pkg::PRIME_X2};

	always_comb begin
		priority if (!diff2[32]) begin
			result = diff2[mexp_pkg::OUT_W-1:0];
		end else if (!diff1[32]) begin
			result = diff1[mexp_pkg::OUT_W-1:0];
		end else begin
			result = rem_s4[mexp_pkg::OUT_W-1:0];
		end
	end

endmodule

// ===== sv/mexp_datapath.sv =====
// Datapath: exponent, square and accumulator registers, two multipliers
// and the output payload register. Depends on mexp_pkg and mexp_modmul.
module mexp_datapath (
	input  logic                          clk,
	input  mexp_pkg::dp_cmd_t             cmd,
	output mexp_pkg::dp_sts_t             sts,
	input  logic [mexp_pkg::IN_W-1:0]     base_value,
	input  logic [mexp_pkg::IN_W-1:0]     exponent,
	output logic [mexp_pkg::OUT_W-1:0]    power_mod
);

	logic [mexp_pkg::IN_W-1:0]  exp_q;
	logic [mexp_pkg::OUT_W-1:0] sq_q;
	logic [mexp_pkg::OUT_W-1:0] acc_q;
	logic [mexp_pkg::OUT_W-1:0] power_mod_q;
	logic [32:0]                sq_a;
	logic [mexp_pkg::OUT_W-1:0] sq_b;
	logic [mexp_pkg::OUT_W-1:0] sq_c;
	logic [mexp_pkg::OUT_W-1:0] sq_res;
	logic [mexp_pkg::OUT_W-1:0] mul_res;

	// On a load the squaring unit folds the wide base, otherwise it squares.
	always_comb begin
		if (cmd.load) begin
			sq_a = base_value[62:30];
			sq_b = mexp_pkg::FOLD_C;
			sq_c = base_value[29:0];
		end else begin
			sq_a = {3'd0, sq_q};
			sq_b = sq_q;
			sq_c = '0;
		end
	end

	mexp_modmul u_square (
		.clk    (clk),
		.op_a   (sq_a),
		.op_b   (sq_b),
		.op_c   (sq_c),
		.result (sq_res)
	);

	mexp_modmul u_multiply (
		.clk    (clk),
		.op_a   ({3'd0, acc_q}),
		.op_b   (sq_q),
		.op_c   ('0),
		.result (mul_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			exp_q <= exponent;
			acc_q <= 30'd1;
		end
		if (cmd.take_base) begin
			sq_q <= sq_res;
		end
		if (cmd.take_step) begin
			sq_q  <= sq_res;
			exp_q <= exp_q >> 1;
			if (exp_q[0]) begin
				acc_q <= mul_res;
			end
		end
		if (cmd.emit) begin
			power_mod_q <= acc_q;
		end
	end

	assign sts.exp_zero = (exp_q == '0);
	assign power_mod    = power_mod_q;

endmodule

// ===== sv/mexp_ctrl.sv =====
// Controller state machine: sequences base reduction and exponent bits,
// and owns both handshakes. Depends on mexp_pkg.
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  mexp_pkg::dp_sts_t sts,
	output mexp_pkg::dp_cmd_t cmd
);

	mexp_pkg::state_t            state_q;
	mexp_pkg::state_t            state_d;
	logic [mexp_pkg::CNT_W-1:0]  cnt_q;
	logic                        out_valid_q;
	logic                        cnt_done;
	logic                        out_free;

	assign cnt_done = (cnt_q == mexp_pkg::CNT_W'(mexp_pkg::MM_LAT - 1));
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mexp_pkg::ST_BASE;
				end
			end
			mexp_pkg::ST_BASE: begin
				if (cnt_done) begin
					state_d = mexp_pkg::ST_STEP;
				end
			end
			mexp_pkg::ST_STEP: begin
				if (sts.exp_zero) begin
					state_d = mexp_pkg::ST_DONE;
				end else begin
					state_d = mexp_pkg::ST_WAIT;
				end
			end
			mexp_pkg::ST_WAIT: begin
				if (cnt_done) begin
					state_d = mexp_pkg::ST_STEP;
				end
			end
			mexp_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = mexp_pkg::ST_IDLE;
				end
			end
			default: state_d = mexp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			mexp_pkg::ST_BASE: cmd.take_base = cnt_done;
			mexp_pkg::ST_STEP: cmd.issue     = !sts.exp_zero;
			mexp_pkg::ST_WAIT: cmd.take_step = cnt_done;
			mexp_pkg::ST_DONE: cmd.emit      = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load || cmd.issue) begin
				cnt_q <= '0;
			end else if (!cnt_done) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/modular_exponentiation.sv =====
// Top level of the modular exponentiation block (base ** exponent mod p).
// Joins the controller and the datapath; depends on mexp_pkg, mexp_ctrl
// and mexp_datapath.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------
//   input   | in_valid / in_stall  | base_value[62:0], exponent[62:0]
//   output  | out_valid / out_stall| power_mod[29:0]
//
// From acceptance to its result, an item first has its base reduced and then
// takes one step for each exponent bit up to and including the highest set
// bit, none for a zero exponent. The base reduction and every step pass once
// through the four-stage Barrett multiplier.
// Reset is asynchronous and clears only the controller; no clearing pass.
// A result waiting under out_stall does not block the next item, which is
// accepted and worked on; it holds only at its own end for a free register.

module modular_exponentiation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mexp_pkg::IN_W-1:0]     base_value,
	input  logic [mexp_pkg::IN_W-1:0]     exponent,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mexp_pkg::OUT_W-1:0]    power_mod
);

	// Commands run from the controller into the datapath; the only status
	// coming back is whether the remaining exponent is zero.
	mexp_pkg::dp_cmd_t cmd;
	mexp_pkg::dp_sts_t sts;

	// The controller first runs the base through the squaring unit, which
	// folds its upper bits with 2^30 mod p and reduces the whole value.
	// Each exponent bit then starts a square and a multiply together and
	// waits out the multiplier depth before the right-to-left step.
	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the running square, the accumulator, the shifting
	// exponent and the output register, which parts the two channels.
	mexp_datapath u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.sts        (sts),
		.base_value (base_value),
		.exponent   (exponent),
		.power_mod  (power_mod)
	);

endmodule
